// ===== hw/rtl/rra_pkg.sv =====
// Shared types and constants for the register ALU execute core.
package rra_pkg;

  localparam int DATA_W      = 32;
  localparam int NUM_REGS    = 32;
  localparam int NUM_SPECIAL = 8;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int SPC_IDX_W   = $clog2(NUM_SPECIAL);
  localparam int OP_W        = 5;
  localparam int STATUS_W    = 2;

  localparam logic [REG_IDX_W-1:0] SHIFT_MASK  = 5'h1F;
  localparam logic [REG_IDX_W-1:0] SPECIAL_MAX = 5'd7;

  typedef enum logic [OP_W-1:0] {
    OP_NOP    = 5'd0,
    OP_HALT   = 5'd1,
    OP_WAIT   = 5'd2,
    OP_SLL    = 5'd3,
    OP_SRL    = 5'd4,
    OP_SRA    = 5'd5,
    OP_SEQU   = 5'd6,
    OP_SNEU   = 5'd7,
    OP_SLTU   = 5'd8,
    OP_SGTU   = 5'd9,
    OP_SLEU   = 5'd10,
    OP_SGEU   = 5'd11,
    OP_ADD    = 5'd12,
    OP_ADDU   = 5'd13,
    OP_SUB    = 5'd14,
    OP_SUBU   = 5'd15,
    OP_AND    = 5'd16,
    OP_OR     = 5'd17,
    OP_XOR    = 5'd18,
    OP_SEQ    = 5'd19,
    OP_SNE    = 5'd20,
    OP_SLT    = 5'd21,
    OP_SGT    = 5'd22,
    OP_SLE    = 5'd23,
    OP_SGE    = 5'd24,
    OP_MOVI2S = 5'd25,
    OP_MOVS2I = 5'd26,
    OP_LOAD   = 5'd27
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_OVERFLOW    = 2'd1,
    ST_BAD_SPECIAL = 2'd2,
    ST_UNKNOWN     = 2'd3
  } status_t;

  typedef struct packed {
    status_t             status;
    logic                gen_wr;
    logic                spc_wr;
    logic                set_halt;
    logic                set_wait;
    logic [DATA_W-1:0]   wr_data;
  } exec_res_t;

endpackage

// ===== hw/rtl/rra_regfile.sv =====
// General register file: one write port, two registered read ports with bypass.
module rra_regfile
  import rra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [REG_IDX_W-1:0] rd_idx_a,
  input  logic [REG_IDX_W-1:0] rd_idx_b,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_idx,
  input  logic [DATA_W-1:0]    wr_data,
  output logic [DATA_W-1:0]    rd_data_a,
  output logic [DATA_W-1:0]    rd_data_b
);

  logic [DATA_W-1:0]   mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic [DATA_W-1:0]   raw_a_r;
  logic [DATA_W-1:0]   raw_b_r;
  logic                vld_a_r;
  logic                vld_b_r;
  logic                hit_a_r;
  logic                hit_b_r;
  logic [DATA_W-1:0]   byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      raw_a_r <= mem[rd_idx_a];
      raw_b_r <= mem[rd_idx_b];
      vld_a_r <= vld_r[rd_idx_a];
      vld_b_r <= vld_r[rd_idx_b];
      hit_a_r <= wr_en && (wr_idx == rd_idx_a);
      hit_b_r <= wr_en && (wr_idx == rd_idx_b);
      byp_r   <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  assign rd_data_a = hit_a_r ? byp_r : (vld_a_r ? raw_a_r : '0);
  assign rd_data_b = hit_b_r ? byp_r : (vld_b_r ? raw_b_r : '0);

endmodule

// ===== hw/rtl/rra_alu.sv =====
// Execute logic: decodes one operation and forms its status and write value.
module rra_alu
  import rra_pkg::*;
(
  input  logic [OP_W-1:0]      op,
  input  logic [REG_IDX_W-1:0] src_a,
  input  logic [REG_IDX_W-1:0] dest,
  input  logic [DATA_W-1:0]    opa,
  input  logic [DATA_W-1:0]    opb,
  input  logic [DATA_W-1:0]    spc_data,
  input  logic [DATA_W-1:0]    load_value,
  output exec_res_t            res
);

  logic [REG_IDX_W-1:0] sh;
  logic [DATA_W-1:0]    sum;
  logic [DATA_W-1:0]    dif;
  logic                 sa_lt;
  logic                 ua_lt;
  logic                 eq;

  assign sh    = opb[REG_IDX_W-1:0] & SHIFT_MASK;
  assign sum   = opa + opb;
  assign dif   = opa - opb;
  assign eq    = (opa == opb);
  assign ua_lt = (opa < opb);
  assign sa_lt = ($signed(opa) < $signed(opb));

  always_comb begin
    res = '{status: ST_OK, gen_wr: 1'b0, spc_wr: 1'b0, set_halt: 1'b0,
            set_wait: 1'b0, wr_data: '0};
    case (op)
      OP_NOP: ;
      OP_HALT: res.set_halt = 1'b1;
      OP_WAIT: res.set_wait = 1'b1;
      OP_SLL: begin res.wr_data = opa << sh; res.gen_wr = 1'b1; end
      OP_SRL: begin res.wr_data = opa >> sh; res.gen_wr = 1'b1; end
      OP_SRA: begin
        res.wr_data = DATA_W'($signed(opa) >>> sh);
        res.gen_wr  = 1'b1;
      end
      OP_SEQU, OP_SEQ: begin res.wr_data = DATA_W'(eq); res.gen_wr = 1'b1; end
      OP_SNEU, OP_SNE: begin res.wr_data = DATA_W'(!eq); res.gen_wr = 1'b1; end
      OP_SLTU: begin res.wr_data = DATA_W'(ua_lt); res.gen_wr = 1'b1; end
      OP_SGTU: begin res.wr_data = DATA_W'(!ua_lt && !eq); res.gen_wr = 1'b1; end
      OP_SLEU: begin res.wr_data = DATA_W'(ua_lt || eq); res.gen_wr = 1'b1; end
      OP_SGEU: begin res.wr_data = DATA_W'(!ua_lt); res.gen_wr = 1'b1; end
      OP_SLT:  begin res.wr_data = DATA_W'(sa_lt); res.gen_wr = 1'b1; end
      OP_SGT:  begin res.wr_data = DATA_W'(!sa_lt && !eq); res.gen_wr = 1'b1; end
      OP_SLE:  begin res.wr_data = DATA_W'(sa_lt || eq); res.gen_wr = 1'b1; end
      OP_SGE:  begin res.wr_data = DATA_W'(!sa_lt); res.gen_wr = 1'b1; end
      OP_ADD: begin
        res.wr_data = sum;
        res.gen_wr  = 1'b1;
        if (((opa ^ sum) & (opb ^ sum)) >> (DATA_W - 1) != '0) begin
          res.status = ST_OVERFLOW;
        end
      end
      OP_ADDU: begin res.wr_data = sum; res.gen_wr = 1'b1; end
      OP_SUB: begin
        res.wr_data = dif;
        res.gen_wr  = 1'b1;
        if (((opa ^ opb) & (opa ^ dif)) >> (DATA_W - 1) != '0) begin
          res.status = ST_OVERFLOW;
        end
      end
      OP_SUBU: begin res.wr_data = dif; res.gen_wr = 1'b1; end
      OP_AND: begin res.wr_data = opa & opb; res.gen_wr = 1'b1; end
      OP_OR:  begin res.wr_data = opa | opb; res.gen_wr = 1'b1; end
      OP_XOR: begin res.wr_data = opa ^ opb; res.gen_wr = 1'b1; end
      OP_MOVI2S: begin
        if (dest inside {[5'd1:SPECIAL_MAX]}) begin
          res.wr_data = opa;
          res.spc_wr  = 1'b1;
        end else begin
          res.status = ST_BAD_SPECIAL;
        end
      end
      OP_MOVS2I: begin
        if (src_a inside {[5'd1:SPECIAL_MAX]}) begin
          res.wr_data = spc_data;
          res.gen_wr  = 1'b1;
        end else begin
          res.status = ST_BAD_SPECIAL;
        end
      end
      OP_LOAD: begin res.wr_data = load_value; res.gen_wr = 1'b1; end
      default: res.status = ST_UNKNOWN;
    endcase
  end

endmodule

// ===== hw/rtl/risc_register_alu_execute_core.sv =====
// Top level of the register ALU execute core: pipeline control and special registers.
// Executes one register instruction per clock, unless stalled, against a 32 x 32-bit
// register file and special registers 1 to 7. A request is accepted every cycle while
// the result side keeps up; its operands are read into the registered read ports, then
// its result is executed into the output register. A result taken back to back
// forwards to the next request, so dependent instructions also issue every cycle. The
// register file clears by per-entry valid bits at reset, with no clearing pass.
module risc_register_alu_execute_core
  import rra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_op,
  input  logic [REG_IDX_W-1:0] in_src_a,
  input  logic [REG_IDX_W-1:0] in_src_b,
  input  logic [REG_IDX_W-1:0] in_dest,
  input  logic [DATA_W-1:0]    in_load_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic                 out_wrote,
  output logic [REG_IDX_W-1:0] out_write_index,
  output logic [DATA_W-1:0]    out_write_data,
  output logic                 out_halted_flag,
  output logic                 out_waiting_flag
);

  logic                 in_acc;
  logic                 s1_adv;
  logic                 s1_vld_r;
  logic                 s1_vld_nxt;
  logic [OP_W-1:0]      s1_op_r;
  logic [REG_IDX_W-1:0] s1_src_a_r;
  logic [REG_IDX_W-1:0] s1_dest_r;
  logic [DATA_W-1:0]    s1_lv_r;
  logic                 out_vld_r;
  logic                 out_vld_nxt;
  logic [STATUS_W-1:0]  out_status_r;
  logic                 out_wrote_r;
  logic [REG_IDX_W-1:0] out_idx_r;
  logic [DATA_W-1:0]    out_data_r;
  logic                 out_halted_r;
  logic                 out_waiting_r;
  logic                 halt_r;
  logic                 halt_nxt;
  logic                 wait_r;
  logic                 wait_nxt;
  logic [DATA_W-1:0]    spc_r [NUM_SPECIAL];
  logic [DATA_W-1:0]    opa;
  logic [DATA_W-1:0]    opb;
  logic [DATA_W-1:0]    spc_rd;
  logic                 wrote;
  exec_res_t            res;

  assign s1_adv      = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall    = s1_vld_r && !s1_adv;
  assign in_acc      = in_valid && !in_stall;
  assign s1_vld_nxt  = in_acc || (s1_vld_r && !s1_adv);
  assign out_vld_nxt = s1_adv || (out_vld_r && out_stall);

  rra_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_acc),
    .rd_idx_a  (in_src_a),
    .rd_idx_b  (in_src_b),
    .wr_en     (s1_adv && res.gen_wr),
    .wr_idx    (s1_dest_r),
    .wr_data   (res.wr_data),
    .rd_data_a (opa),
    .rd_data_b (opb)
  );

  assign spc_rd = spc_r[s1_src_a_r[SPC_IDX_W-1:0]];

  rra_alu u_alu (
    .op         (s1_op_r),
    .src_a      (s1_src_a_r),
    .dest       (s1_dest_r),
    .opa        (opa),
    .opb        (opb),
    .spc_data   (spc_rd),
    .load_value (s1_lv_r),
    .res        (res)
  );

  assign wrote    = res.gen_wr || res.spc_wr;
  assign halt_nxt = halt_r || res.set_halt;
  assign wait_nxt = wait_r || res.set_wait;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      halt_r    <= 1'b0;
      wait_r    <= 1'b0;
      for (int i = 0; i < NUM_SPECIAL; i++) begin
        spc_r[i] <= '0;
      end
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (s1_adv) begin
        halt_r <= halt_nxt;
        wait_r <= wait_nxt;
        if (res.spc_wr) begin
          spc_r[s1_dest_r[SPC_IDX_W-1:0]] <= res.wr_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_op;
      s1_src_a_r <= in_src_a;
      s1_dest_r  <= in_dest;
      s1_lv_r    <= in_load_value;
    end
    if (s1_adv) begin
      out_status_r  <= res.status;
      out_wrote_r   <= wrote;
      out_idx_r     <= wrote ? s1_dest_r : '0;
      out_data_r    <= wrote ? res.wr_data : '0;
      out_halted_r  <= halt_nxt;
      out_waiting_r <= wait_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_status       = out_status_r;
  assign out_wrote        = out_wrote_r;
  assign out_write_index  = out_idx_r;
  assign out_write_data   = out_data_r;
  assign out_halted_flag  = out_halted_r;
  assign out_waiting_flag = out_waiting_r;

  a_idle_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_wrote_r |-> out_idx_r == '0 && out_data_r == '0)
    else $error("result without write carries nonzero index or data");

  a_overflow_writes: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_status_r == ST_OVERFLOW |-> out_wrote_r)
    else $error("overflow result without register write");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_halted_r |=> out_halted_r)
    else $error("halt flag cleared after being set");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r && out_vld_r && out_stall)
    else $error("input stalled without a full pipeline");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the register ALU execute core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rra_pkg::*;

  localparam logic [OP_W-1:0] OP_FIRST_UNKNOWN = 5'd28;
  localparam logic [OP_W-1:0] OP_LAST_CODE     = 5'd31;
  localparam int NUM_RANDOM   = 1000;
  localparam int MAX_PRINTED  = 40;

  typedef struct packed {
    status_t               status;
    logic                  wrote;
    logic [REG_IDX_W-1:0]  index;
    logic [DATA_W-1:0]     data;
    logic                  halted;
    logic                  waiting;
  } retire_t;

  class retire_scoreboard;
    logic [DATA_W-1:0] gpr [NUM_REGS];
    logic [DATA_W-1:0] spr [NUM_SPECIAL];
    logic              halted;
    logic              waiting;
    retire_t           expected_retires [$];
    int                errors;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      foreach (spr[i]) spr[i] = '0;
      halted  = 1'b0;
      waiting = 1'b0;
      errors  = 0;
    endfunction

    function int pending();
      return expected_retires.size();
    endfunction

    task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      if (errors < MAX_PRINTED)
        $display("%0t ns  %s: got %h, want %h", $time, what, got, want);
      errors++;
    endtask

    function retire_t retire_of(logic [OP_W-1:0] op, logic [REG_IDX_W-1:0] ia,
                                logic [REG_IDX_W-1:0] ib, logic [REG_IDX_W-1:0] id,
                                logic [DATA_W-1:0] lv);
      retire_t           r;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] v;
      logic              gen;
      logic              spc;
      a        = gpr[ia];
      b        = gpr[ib];
      v        = '0;
      gen      = 1'b0;
      spc      = 1'b0;
      r.status = ST_OK;
      case (op)
        OP_NOP:  ;
        OP_HALT: halted = 1'b1;
        OP_WAIT: waiting = 1'b1;
        OP_SLL:  begin v = a << b[4:0]; gen = 1'b1; end
        OP_SRL:  begin v = a >> b[4:0]; gen = 1'b1; end
        OP_SRA:  begin v = $signed(a) >>> b[4:0]; gen = 1'b1; end
        OP_SEQU: begin v = DATA_W'(a == b); gen = 1'b1; end
        OP_SNEU: begin v = DATA_W'(a != b); gen = 1'b1; end
        OP_SLTU: begin v = DATA_W'(a < b); gen = 1'b1; end
        OP_SGTU: begin v = DATA_W'(a > b); gen = 1'b1; end
        OP_SLEU: begin v = DATA_W'(a <= b); gen = 1'b1; end
        OP_SGEU: begin v = DATA_W'(a >= b); gen = 1'b1; end
        OP_ADD: begin
          v   = a + b;
          gen = 1'b1;
          if (a[31] == b[31] && v[31] != a[31]) r.status = ST_OVERFLOW;
        end
        OP_ADDU: begin v = a + b; gen = 1'b1; end
        OP_SUB: begin
          v   = a - b;
          gen = 1'b1;
          if (a[31] != b[31] && v[31] != a[31]) r.status = ST_OVERFLOW;
        end
        OP_SUBU: begin v = a - b; gen = 1'b1; end
        OP_AND:  begin v = a & b; gen = 1'b1; end
        OP_OR:   begin v = a | b; gen = 1'b1; end
        OP_XOR:  begin v = a ^ b; gen = 1'b1; end
        OP_SEQ:  begin v = DATA_W'($signed(a) == $signed(b)); gen = 1'b1; end
        OP_SNE:  begin v = DATA_W'($signed(a) != $signed(b)); gen = 1'b1; end
        OP_SLT:  begin v = DATA_W'($signed(a) < $signed(b)); gen = 1'b1; end
        OP_SGT:  begin v = DATA_W'($signed(a) > $signed(b)); gen = 1'b1; end
        OP_SLE:  begin v = DATA_W'($signed(a) <= $signed(b)); gen = 1'b1; end
        OP_SGE:  begin v = DATA_W'($signed(a) >= $signed(b)); gen = 1'b1; end
        OP_MOVI2S: begin
          if (id >= 1 && id <= SPECIAL_MAX) begin
            v   = a;
            spc = 1'b1;
          end else begin
            r.status = ST_BAD_SPECIAL;
          end
        end
        OP_MOVS2I: begin
          if (ia >= 1 && ia <= SPECIAL_MAX) begin
            v   = spr[ia[SPC_IDX_W-1:0]];
            gen = 1'b1;
          end else begin
            r.status = ST_BAD_SPECIAL;
          end
        end
        OP_LOAD: begin v = lv; gen = 1'b1; end
        default: r.status = ST_UNKNOWN;
      endcase
      if (gen) gpr[id] = v;
      if (spc) spr[id[SPC_IDX_W-1:0]] = v;
      r.wrote   = gen | spc;
      r.index   = r.wrote ? id : '0;
      r.data    = r.wrote ? v : '0;
      r.halted  = halted;
      r.waiting = waiting;
      return r;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [REG_IDX_W-1:0] ia,
                               logic [REG_IDX_W-1:0] ib, logic [REG_IDX_W-1:0] id,
                               logic [DATA_W-1:0] lv);
      expected_retires.push_back(retire_of(op, ia, ib, id, lv));
    endfunction

    task check_result(retire_t got);
      retire_t want;
      if (expected_retires.size() == 0) begin
        report_mismatch("result with no request pending", got.data, '0);
      end else begin
        want = expected_retires.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", DATA_W'(got.status), DATA_W'(want.status));
        if (got.wrote !== want.wrote)
          report_mismatch("wrote", DATA_W'(got.wrote), DATA_W'(want.wrote));
        if (got.index !== want.index)
          report_mismatch("write_index", DATA_W'(got.index), DATA_W'(want.index));
        if (got.data !== want.data)
          report_mismatch("write_data", got.data, want.data);
        if (got.halted !== want.halted)
          report_mismatch("halted_flag", DATA_W'(got.halted), DATA_W'(want.halted));
        if (got.waiting !== want.waiting)
          report_mismatch("waiting_flag", DATA_W'(got.waiting), DATA_W'(want.waiting));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      in_op;
  logic [REG_IDX_W-1:0] in_src_a;
  logic [REG_IDX_W-1:0] in_src_b;
  logic [REG_IDX_W-1:0] in_dest;
  logic [DATA_W-1:0]    in_load_value;
  logic                 out_valid;
  logic                 out_stall;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_wrote;
  logic [REG_IDX_W-1:0] out_write_index;
  logic [DATA_W-1:0]    out_write_data;
  logic                 out_halted_flag;
  logic                 out_waiting_flag;

  retire_scoreboard book = new();

  risc_register_alu_execute_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_src_a         (in_src_a),
    .in_src_b         (in_src_b),
    .in_dest          (in_dest),
    .in_load_value    (in_load_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_wrote        (out_wrote),
    .out_write_index  (out_write_index),
    .out_write_data   (out_write_data),
    .out_halted_flag  (out_halted_flag),
    .out_waiting_flag (out_waiting_flag)
  );

  always #5 clk = ~clk;

  task automatic send_request(input logic [OP_W-1:0] op, input logic [REG_IDX_W-1:0] ia,
                              input logic [REG_IDX_W-1:0] ib, input logic [REG_IDX_W-1:0] id,
                              input logic [DATA_W-1:0] lv);
    in_valid      <= 1'b1;
    in_op         <= op;
    in_src_a      <= ia;
    in_src_b      <= ib;
    in_dest       <= id;
    in_load_value <= lv;
    do @(posedge clk); while (in_stall);
    book.note_request(op, ia, ib, id, lv);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic logic [REG_IDX_W-1:0] pick_reg();
    if ($urandom_range(0, 1) == 0) return REG_IDX_W'($urandom_range(0, 7));
    return REG_IDX_W'($urandom_range(0, NUM_REGS - 1));
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      1: return DATA_W'($urandom_range(0, 40));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random();
    logic [OP_W-1:0]      op;
    logic [REG_IDX_W-1:0] ia;
    logic [REG_IDX_W-1:0] ib;
    logic [REG_IDX_W-1:0] id;
    int                   pick;
    pick = $urandom_range(0, 99);
    if (pick < 18) op = OP_LOAD;
    else if (pick < 22) op = OP_W'($urandom_range(OP_FIRST_UNKNOWN, OP_LAST_CODE));
    else op = OP_W'($urandom_range(OP_NOP, OP_LOAD));
    ia = pick_reg();
    ib = ($urandom_range(0, 7) == 0) ? ia : pick_reg();
    id = pick_reg();
    if (op == OP_MOVI2S && $urandom_range(0, 3) != 0)
      id = REG_IDX_W'($urandom_range(1, SPECIAL_MAX));
    if (op == OP_MOVS2I && $urandom_range(0, 3) != 0)
      ia = REG_IDX_W'($urandom_range(1, SPECIAL_MAX));
    send_request(op, ia, ib, id, pick_value());
  endtask

  initial begin : stimulus
    int burst_left;
    int gap;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_NOP;
    in_src_a      = '0;
    in_src_b      = '0;
    in_dest       = '0;
    in_load_value = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(OP_LOAD, 5'd1, 5'd0, 5'd1, 32'hFFFF_FFFF);
    send_request(OP_LOAD, 5'd0, 5'd0, 5'd2, 32'h8000_0000);
    send_request(OP_LOAD, 5'd0, 5'd0, 5'd3, 32'h7FFF_FFFF);
    send_request(OP_LOAD, 5'd0, 5'd0, 5'd4, 32'h0000_0001);
    send_request(OP_LOAD, 5'd31, 5'd31, 5'd0, 32'h0000_0023);
    send_request(OP_LOAD, 5'd0, 5'd0, 5'd5, 32'h0000_0000);
    for (int k = 0; k <= OP_LAST_CODE; k++)
      send_request(OP_W'(k), k[0] ? 5'd2 : 5'd3, (k < OP_SEQU) ? 5'd0 : (k[1] ? 5'd1 : 5'd4),
                   REG_IDX_W'(31 - k % 16), 32'hA5A5_5A5A);
    send_request(OP_MOVI2S, 5'd1, 5'd0, 5'd7, 32'h0);
    send_request(OP_MOVI2S, 5'd1, 5'd0, 5'd0, 32'h0);
    send_request(OP_MOVS2I, 5'd7, 5'd0, 5'd31, 32'h0);
    send_request(OP_MOVS2I, 5'd0, 5'd0, 5'd30, 32'h0);
    send_request(OP_SGE, 5'd2, 5'd2, 5'd29, 32'hFFFF_FFFF);
    send_request(OP_SGEU, 5'd1, 5'd1, 5'd28, 32'h0);

    burst_left = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) pause_sender(gap);
        burst_left = $urandom_range(1, 40);
      end
      send_random();
      burst_left--;
    end
    in_valid <= 1'b0;

    while (book.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0)
      $display("risc_register_alu_execute_core: match");
    else
      $display("risc_register_alu_execute_core: mismatch");
    $finish;
  end

  initial begin : receiver
    int  mode;
    int  span;
    int  cyc;
    bit  long_done;
    out_stall = 1'b0;
    cyc       = 0;
    long_done = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 120);
      if (cyc >= 300 && !long_done) begin
        mode      = 4;
        long_done = 1'b1;
      end else if ($urandom_range(0, 29) == 0) begin
        mode = 4;
      end
      if (mode == 4) span = $urandom_range(60, 150);
      repeat (span) begin
        @(negedge clk);
        cyc++;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          2: out_stall <= (cyc % 4 == 0);
          3: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    retire_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.status  = status_t'(out_status);
      got.wrote   = out_wrote;
      got.index   = out_write_index;
      got.data    = out_write_data;
      got.halted  = out_halted_flag;
      got.waiting = out_waiting_flag;
      book.check_result(got);
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("risc_register_alu_execute_core: mismatch");
    $finish;
  end

endmodule
